/* src/insertion_sorter_core_defines.svh */
// ----------------------------------------------------------------------------
// insertion sorter assertion macros
// shared property forms used by the port checker
// ----------------------------------------------------------------------------
`ifndef INSERTION_SORTER_CORE_DEFINES_SVH
`define INSERTION_SORTER_CORE_DEFINES_SVH

// same-cycle implication
`define ISORT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("isort check failed");

// next-cycle implication
`define ISORT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("isort check failed");

`endif

/* src/isort_pkg.sv */
// ----------------------------------------------------------------------------
// isort_pkg
// sizes, types and controller states of the insertion sorter
// ----------------------------------------------------------------------------
package isort_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;

    typedef logic signed [DATA_WIDTH-1:0] value_t;

    typedef enum logic
    {
        ST_COLLECT,
        ST_DRAIN
    } state_t;

    typedef struct packed
    {
        logic insert;
        logic shift;
    } cell_ctrl_t;

endpackage

/* src/isort_in_if.sv */
// ----------------------------------------------------------------------------
// isort_in_if
// input channel: one set element per beat, last marks the end of the set
// ----------------------------------------------------------------------------
interface isort_in_if
    import isort_pkg::*;
();
    logic   valid;
    logic   ready;
    value_t value;
    logic   last;

    modport source (output valid, output value, output last, input ready);
    modport sink (input valid, input value, input last, output ready);
endinterface

/* src/isort_out_if.sv */
// ----------------------------------------------------------------------------
// isort_out_if
// output channel: sorted elements, one per beat
// ----------------------------------------------------------------------------
interface isort_out_if
    import isort_pkg::*;
();
    logic   valid;
    logic   ready;
    value_t sorted_value;
    logic   last_out;
    logic   overflow;

    modport source (output valid, output sorted_value, output last_out, output overflow,
                    input ready);
    modport sink (input valid, input sorted_value, input last_out, input overflow,
                  output ready);
endinterface

/* src/insertion_sorter_core.sv */
// ----------------------------------------------------------------------------
// insertion_sorter_core
// streaming insertion sort of one set into a chain of compare-and-shift cells
//
//   port      role   payload
//   items     sink   value, last
//   results   source sorted_value, last_out, overflow
//
// one element per cycle while collecting; every cell compares and shifts at once
// after the last element the set leaves from the head cell, one per cycle
// items.ready is low while a set drains; it returns the cycle after the final beat
// a stall on results holds the chain; elements beyond the chain depth are dropped
// rst_n clears the slot valid bits, the drop flag and the controller
// ----------------------------------------------------------------------------
module insertion_sorter_core
    import isort_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    isort_in_if.sink     items,
    isort_out_if.source  results
);

    state_t     state_reg;
    state_t     state_next;
    logic       dropped_reg;
    logic       dropped_next;
    cell_ctrl_t ctrl;
    logic       in_beat;
    logic       out_beat;
    logic       full;

    value_t cell_value [DEPTH];
    logic   cell_valid [DEPTH];
    logic   cell_ins   [DEPTH];

    genvar i;
    generate
        for (i = 0; i < DEPTH; i++)
        begin : g_cell
            value_t prev_value;
            logic   prev_valid;
            logic   prev_ins;
            value_t next_value;
            logic   next_valid;

            if (i == 0)
            begin : g_head
                assign prev_value = '0;
                assign prev_valid = 1'b1;
                assign prev_ins   = 1'b0;
            end
            else
            begin : g_body
                assign prev_value = cell_value[i-1];
                assign prev_valid = cell_valid[i-1];
                assign prev_ins   = cell_ins[i-1];
            end

            if (i == DEPTH - 1)
            begin : g_tail
                assign next_value = '0;
                assign next_valid = 1'b0;
            end
            else
            begin : g_link
                assign next_value = cell_value[i+1];
                assign next_valid = cell_valid[i+1];
            end

            isort_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .new_value  (items.value),
                .prev_value (prev_value),
                .prev_valid (prev_valid),
                .prev_ins   (prev_ins),
                .next_value (next_value),
                .next_valid (next_valid),
                .value      (cell_value[i]),
                .valid      (cell_valid[i]),
                .ins        (cell_ins[i])
            );
        end
    endgenerate

    assign full     = cell_valid[DEPTH-1];
    assign in_beat  = items.valid && items.ready;
    assign out_beat = results.valid && results.ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_COLLECT:
            begin
                if (in_beat && items.last)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (out_beat && results.last_out)
                begin
                    state_next = ST_COLLECT;
                end
            end
            default:
            begin
                state_next = ST_COLLECT;
            end
        endcase
    end

    always_comb
    begin
        items.ready   = 1'b0;
        results.valid = 1'b0;
        case (state_reg)
            ST_COLLECT:
            begin
                items.ready = 1'b1;
            end
            ST_DRAIN:
            begin
                results.valid = 1'b1;
            end
            default:
            begin
                items.ready   = 1'b0;
                results.valid = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        ctrl.insert  = in_beat && !full;
        ctrl.shift   = out_beat;
        dropped_next = dropped_reg || (in_beat && full);
        if (out_beat && results.last_out)
        begin
            dropped_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_COLLECT;
            dropped_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            dropped_reg <= dropped_next;
        end
    end

    assign results.sorted_value = cell_value[0];
    assign results.last_out     = !cell_valid[1];
    assign results.overflow     = dropped_reg;

endmodule

/* src/isort_cell.sv */
// ----------------------------------------------------------------------------
// isort_cell
// one slot of the sorted chain: keeps, takes the new value, or takes a neighbor
// ----------------------------------------------------------------------------
module isort_cell
    import isort_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cell_ctrl_t ctrl,
    input  value_t     new_value,
    input  value_t     prev_value,
    input  logic       prev_valid,
    input  logic       prev_ins,
    input  value_t     next_value,
    input  logic       next_valid,
    output value_t     value,
    output logic       valid,
    output logic       ins
);

    value_t value_reg;
    value_t value_next;
    logic   valid_reg;
    logic   valid_next;

    // slot is empty or holds a value greater than the new one
    assign ins = !valid_reg || (value_reg > new_value);

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.shift)
        begin
            value_next = next_value;
            valid_next = next_valid;
        end
        else if (ctrl.insert && ins)
        begin
            value_next = prev_ins ? prev_value : new_value;
            valid_next = valid_reg || prev_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

/* src/isort_checker.sv */
// ----------------------------------------------------------------------------
// isort_checker
// port-level checks of the insertion sorter, bound to the top level
// ----------------------------------------------------------------------------
`include "insertion_sorter_core_defines.svh"

module isort_checker
    import isort_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   in_valid,
    input logic   in_ready,
    input logic   in_last,
    input logic   out_valid,
    input logic   out_ready,
    input logic   out_last,
    input logic   out_overflow
);

    logic in_beat;
    logic out_beat;

    assign in_beat  = in_valid && in_ready;
    assign out_beat = out_valid && out_ready;

    // collecting and draining never overlap
    `ISORT_ASSERT_SAME(a_no_overlap, out_valid, !in_ready)
    // a set end starts the drain in the next cycle
    `ISORT_ASSERT_NEXT(a_drain_starts, in_beat && in_last, out_valid)
    // the final beat hands control back to collecting
    `ISORT_ASSERT_NEXT(a_drain_ends, out_beat && out_last, in_ready && !out_valid)
    // the overflow flag is constant across one sorted run
    `ISORT_ASSERT_NEXT(a_overflow_held, out_beat && !out_last, $stable(out_overflow))

endmodule

bind insertion_sorter_core isort_checker u_isort_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (items.valid),
    .in_ready     (items.ready),
    .in_last      (items.last),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .out_last     (results.last_out),
    .out_overflow (results.overflow)
);

/* dv/tb_insertion_sorter_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_insertion_sorter_core
// streams sets of signed values into the sorter and checks each sorted beat,
// its end-of-run mark and its overflow flag against a predicted sorted set;
// directed sets cover the value extremes, ties and a full store, random sets
// cover short, full and overflowing sets under random stalls on both sides
// ----------------------------------------------------------------------------
module tb_insertion_sorter_core;
    import isort_pkg::*;

    localparam int ITEM_COUNT     = 470;
    localparam int TAIL_START     = 400;
    localparam int LONG_HOLD      = 300;
    localparam int DRAIN_SETTLE   = 24;
    localparam int WATCHDOG_LIMIT = 4000;

    localparam value_t VALUE_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
    localparam value_t VALUE_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

    typedef enum int
    {
        SPREAD_FULL,
        SPREAD_NARROW,
        SPREAD_EXTREME
    } spread_t;

    typedef struct
    {
        value_t value;
        logic   last;
        logic   overflow;
    } sorted_beat_t;

    class sort_scoreboard;
        value_t       held_set[$];
        bit           set_lost;
        sorted_beat_t sorted_q[$];
        int           errors;

        task report(input string msg);
            $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        function void note_item(input value_t v, input logic l);
            int           pos;
            sorted_beat_t beat;
            if (held_set.size() < DEPTH)
            begin
                pos = held_set.size();
                while (pos > 0 && held_set[pos-1] > v)
                begin
                    pos--;
                end
                held_set.insert(pos, v);
            end
            else
            begin
                set_lost = 1'b1;
            end
            if (l)
            begin
                foreach (held_set[k])
                begin
                    beat.value    = held_set[k];
                    beat.last     = (k == held_set.size() - 1);
                    beat.overflow = set_lost;
                    sorted_q.push_back(beat);
                end
                held_set.delete();
                set_lost = 1'b0;
            end
        endfunction

        task check_result(input value_t v, input logic l, input logic o);
            sorted_beat_t want;
            if (sorted_q.size() == 0)
            begin
                report($sformatf("result %0d with nothing pending", v));
                return;
            end
            want = sorted_q.pop_front();
            if (v !== want.value)
                report($sformatf("sorted_value %0d, predicted %0d", v, want.value));
            if (l !== want.last)
                report($sformatf("last_out %b, predicted %b", l, want.last));
            if (o !== want.overflow)
                report($sformatf("overflow %b, predicted %b", o, want.overflow));
        endtask

        function int pending();
            return sorted_q.size();
        endfunction
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    isort_in_if  items_if();
    isort_out_if results_if();

    insertion_sorter_core dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .items   (items_if),
        .results (results_if)
    );

    sort_scoreboard sb = new();

    bit quiet_tail;
    bit hold_request;
    int stall_left;
    int items_sent;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side: check each beat, then choose ready for the next cycle
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (results_if.valid && results_if.ready)
                sb.check_result(results_if.sorted_value, results_if.last_out,
                                results_if.overflow);
            if (stall_left > 0)
            begin
                stall_left--;
                results_if.ready <= 1'b0;
            end
            else if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left = LONG_HOLD - 1;
                results_if.ready <= 1'b0;
            end
            else if (!quiet_tail && $urandom_range(0, 5) == 0)
            begin
                stall_left = $urandom_range(0, 12);
                results_if.ready <= 1'b0;
            end
            else
            begin
                results_if.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((items_if.valid && items_if.ready) || (results_if.valid && results_if.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    function automatic value_t pick_value(input spread_t spread);
        case (spread)
            SPREAD_FULL:
                return value_t'($urandom);
            SPREAD_NARROW:
                return value_t'($urandom_range(0, 15)) - 8;
            default:
                case ($urandom_range(0, 6))
                    0: return VALUE_MAX;
                    1: return VALUE_MIN;
                    2: return VALUE_MAX - 1;
                    3: return VALUE_MIN + 1;
                    4: return '0;
                    5: return '1;
                    default: return value_t'($urandom);
                endcase
        endcase
    endfunction

    task automatic send_item(input value_t v, input logic l, input bit steady);
        if (!quiet_tail && !steady && $urandom_range(0, 4) == 0)
        begin
            items_if.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        items_if.valid <= 1'b1;
        items_if.value <= v;
        items_if.last  <= l;
        @(posedge clk);
        while (!items_if.ready) @(posedge clk);
        sb.note_item(v, l);
        items_sent++;
    endtask

    task automatic send_set(input int len, input spread_t spread);
        bit steady;
        steady = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++)
            send_item(pick_value(spread), i == len - 1, steady);
    endtask

    initial
    begin
        int      len;
        spread_t spread;
        bit      hold_done;
        bit      pause_done;

        hold_done        = 1'b0;
        pause_done       = 1'b0;
        quiet_tail       = 1'b0;
        hold_request     = 1'b0;
        stall_left       = 0;
        items_sent       = 0;
        items_if.valid   = 1'b0;
        items_if.value   = '0;
        items_if.last    = 1'b0;
        results_if.ready = 1'b0;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // extremes and a tie
        send_item(VALUE_MAX, 1'b0, 1'b0);
        send_item(VALUE_MIN, 1'b0, 1'b0);
        send_item('0, 1'b0, 1'b0);
        send_item('1, 1'b0, 1'b0);
        send_item(value_t'(1), 1'b0, 1'b0);
        send_item(value_t'(5), 1'b0, 1'b0);
        send_item(value_t'(5), 1'b1, 1'b0);
        // single-element set
        send_item(-value_t'(7), 1'b1, 1'b1);
        // reverse order fills the store, then the marked element is dropped
        for (int i = 0; i < DEPTH; i++)
            send_item(value_t'(100 - 3 * i), 1'b0, 1'b1);
        send_item(-value_t'(1000), 1'b1, 1'b1);

        while (items_sent < ITEM_COUNT)
        begin
            if (!hold_done && items_sent >= 150)
            begin
                hold_done = 1'b1;
                hold_request = 1'b1;
            end
            if (!pause_done && items_sent >= 300)
            begin
                pause_done = 1'b1;
                items_if.valid <= 1'b0;
                @(posedge clk);
                while (sb.pending() != 0) @(posedge clk);
            end
            quiet_tail = (items_sent >= TAIL_START);
            case ($urandom_range(0, 9))
                0, 1: len = $urandom_range(DEPTH + 1, DEPTH + 8);
                2:    len = DEPTH;
                default: len = $urandom_range(1, DEPTH);
            endcase
            spread = spread_t'($urandom_range(0, 2));
            send_set(len, spread);
        end

        items_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_SETTLE) @(posedge clk);
        if (sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
